### rtl/ppu_pkg.sv
// ----------------------------------------------------------------------------
// ppu_pkg
// shared types, constants and saturation helpers for the particle pool update
// ----------------------------------------------------------------------------
`default_nettype none

package ppu_pkg;

    // opcode values
    localparam logic OP_EMIT = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int LANE_W = 16;
    localparam int E_W    = 17;   // elapsed time, unsigned Q5.12
    localparam int F_W    = 33;   // life fraction, unsigned Q.16, may exceed 1.0
    localparam int MA_W   = 20;   // signed multiplier operand
    localparam int MB_W   = 17;   // unsigned multiplier operand
    localparam int PROD_W = 38;
    localparam int ACC_W  = 54;
    localparam int VEL_W  = 36;
    localparam int FIN_W  = 44;

    // datapath step numbers within one slot
    localparam logic [3:0] STEP_SIZE0  = 4'd3;
    localparam logic [3:0] STEP_COLOR0 = 4'd5;
    localparam logic [3:0] STEP_ROT    = 4'd9;
    localparam logic [3:0] STEP_POS0   = 4'd10;
    localparam logic [3:0] STEP_LAST   = 4'd12;

    typedef struct packed {
        logic [47:0] position;
        logic [47:0] vel_begin;
        logic [47:0] vel_end;
        logic [63:0] color_begin;
        logic [63:0] color_end;
        logic [31:0] size_begin;
        logic [31:0] size_end;
        logic [31:0] rotation_pair;
        logic [15:0] lifetime;
    } t_rec;

    typedef struct packed {
        logic        is_tick;
        logic [15:0] dt;
        t_rec        rec;
    } t_cmd;

    typedef struct packed {
        logic [47:0] position;
        logic [31:0] size;
        logic [63:0] color;
        logic [15:0] rotation;
    } t_res;

    typedef struct packed {
        t_res res;
        logic last;
    } t_out;

    function automatic logic [15:0] sat_s16(input logic signed [FIN_W-1:0] v);
        logic [15:0] r;
        if (v > FIN_W'(32767)) begin
            r = 16'h7fff;
        end else if (v < -FIN_W'(32768)) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] sat_u16(input logic signed [FIN_W-1:0] v);
        logic [15:0] r;
        if (v > FIN_W'(65535)) begin
            r = 16'hffff;
        end else if (v < FIN_W'(0)) begin
            r = 16'h0000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/ppu_fifo.sv
// ----------------------------------------------------------------------------
// ppu_fifo
// two-entry queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_empty,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic             wr;
    logic             rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (wr) begin
                r_wptr <= !r_wptr;
            end
            if (rd) begin
                r_rptr <= !r_rptr;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/ppu_div.sv
// ----------------------------------------------------------------------------
// ppu_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [ppu_pkg::F_W-1:0] i_dividend,
    input  wire logic [15:0]           i_divisor,
    output logic                       o_done,
    output logic [ppu_pkg::F_W-1:0]    o_quot
);

    logic                    r_busy;
    logic                    r_done;
    logic [5:0]              r_cnt;
    logic [15:0]             r_rem;
    logic [15:0]             r_div;
    logic [ppu_pkg::F_W-1:0] r_quo;
    logic [16:0]             trial;
    logic [16:0]             diff;
    logic                    ge;

    assign trial  = {r_rem, r_quo[ppu_pkg::F_W-1]};
    assign ge     = (trial >= {1'b0, r_div});
    assign diff   = trial - {1'b0, r_div};
    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(ppu_pkg::F_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= 16'd0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so 16 bits hold it
            r_rem <= ge ? diff[15:0] : trial[15:0];
            r_quo <= {r_quo[ppu_pkg::F_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

### rtl/ppu_front.sv
// ----------------------------------------------------------------------------
// ppu_front
// accepts items, classifies emit or tick and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          push,
    output logic               full,
    input  wire logic          i_opcode,
    input  wire logic [15:0]   i_delta_time,
    input  wire logic [47:0]   i_start_position,
    input  wire logic [47:0]   i_begin_velocity,
    input  wire logic [47:0]   i_end_velocity,
    input  wire logic [63:0]   i_begin_color,
    input  wire logic [63:0]   i_end_color,
    input  wire logic [31:0]   i_begin_size,
    input  wire logic [31:0]   i_end_size,
    input  wire logic [15:0]   i_begin_rotation,
    input  wire logic [15:0]   i_end_rotation,
    input  wire logic [15:0]   i_life_time,
    output logic               o_cmd_empty,
    input  wire logic          i_cmd_pop,
    output ppu_pkg::t_cmd      o_cmd
);

    ppu_pkg::t_cmd cmd_in;
    logic [$bits(ppu_pkg::t_cmd)-1:0] cmd_q;

    always_comb begin
        cmd_in.is_tick            = (i_opcode != ppu_pkg::OP_EMIT);
        cmd_in.dt                 = i_delta_time;
        cmd_in.rec.position       = i_start_position;
        cmd_in.rec.vel_begin      = i_begin_velocity;
        cmd_in.rec.vel_end        = i_end_velocity;
        cmd_in.rec.color_begin    = i_begin_color;
        cmd_in.rec.color_end      = i_end_color;
        cmd_in.rec.size_begin     = i_begin_size;
        cmd_in.rec.size_end       = i_end_size;
        cmd_in.rec.rotation_pair  = {i_end_rotation, i_begin_rotation};
        cmd_in.rec.lifetime       = i_life_time;
    end

    ppu_fifo #(
        .WIDTH ($bits(ppu_pkg::t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_data  (cmd_in),
        .o_empty (o_cmd_empty),
        .i_pop   (i_cmd_pop),
        .o_data  (cmd_q)
    );

    assign o_cmd = ppu_pkg::t_cmd'(cmd_q);

endmodule

`default_nettype wire

### rtl/ppu_back.sv
// ----------------------------------------------------------------------------
// ppu_back
// slot store, tick walk sequencer and shared multiply datapath
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_back #(
    parameter int POOL_SIZE = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_empty,
    output logic               o_cmd_pop,
    input  wire ppu_pkg::t_cmd i_cmd,
    output logic               o_res_push,
    input  wire logic          i_res_full,
    output ppu_pkg::t_out      o_res
);

    localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(POOL_SIZE - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_CHECK, S_DIV, S_MAC, S_PUSH, S_FLUSH
    } t_state;

    t_state r_state;

    // slot store
    ppu_pkg::t_rec      r_rec_mem [POOL_SIZE];
    logic signed [16:0] r_tr_mem  [POOL_SIZE];
    ppu_pkg::t_rec      r_rec_q;
    logic signed [16:0] r_tr_q;
    logic [POOL_SIZE-1:0] r_active;
    logic [IDX_W-1:0]   r_next;
    logic [IDX_W-1:0]   r_slot;
    logic [15:0]        r_dt;

    // per-slot working values
    logic [ppu_pkg::E_W-1:0]          r_e;
    logic [ppu_pkg::F_W-1:0]          r_f;
    logic [3:0]                       r_step;
    logic [1:0]                       r_ph;
    logic signed [ppu_pkg::PROD_W-1:0] r_prod;
    logic signed [ppu_pkg::ACC_W-1:0]  r_acc;
    logic [ppu_pkg::VEL_W-1:0]        r_vel [3];
    ppu_pkg::t_res                    r_cur;
    ppu_pkg::t_res                    r_pend;
    logic                             r_pend_v;
    logic                             r_push;
    ppu_pkg::t_out                    r_out;

    // tick arithmetic on the slot just read
    logic signed [17:0] new18;
    logic signed [17:0] e18;
    logic [ppu_pkg::E_W-1:0] e_c;
    logic live;
    logic div_done;
    logic [ppu_pkg::F_W-1:0] div_quot;

    always_comb begin
        new18 = 18'(r_tr_q) - $signed({2'b00, r_dt});
        e18   = $signed({2'b00, r_rec_q.lifetime}) - new18;
        e_c   = (e18 < 18'sd0) ? '0 : e18[16:0];
        live  = (r_tr_q > 17'sd0);
    end

    ppu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    ((r_state == S_CHECK) && live),
        .i_dividend ({e_c, 16'd0}),
        .i_divisor  (r_rec_q.lifetime),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // operand selection for the current step
    logic [1:0]              li;
    logic [15:0]             la;
    logic [15:0]             lb;
    logic                    lsgn;
    logic signed [16:0]      a17;
    logic signed [16:0]      b17;
    logic signed [16:0]      d17;
    logic [ppu_pkg::VEL_W-1:0] vel_sel;
    logic signed [ppu_pkg::MA_W-1:0] m_a;
    logic [ppu_pkg::MB_W-1:0]  m_b;
    logic signed [ppu_pkg::PROD_W-1:0] prod_c;
    logic signed [ppu_pkg::ACC_W-1:0]  acc_sh16;
    logic signed [ppu_pkg::ACC_W-1:0]  acc_sh12;
    logic signed [ppu_pkg::FIN_W-1:0]  lerp_v;
    logic signed [ppu_pkg::FIN_W-1:0]  pos_v;
    logic                    is_pos;

    always_comb begin
        li      = 2'd0;
        la      = '0;
        lb      = '0;
        lsgn    = 1'b1;
        is_pos  = 1'b0;
        priority if (r_step < ppu_pkg::STEP_SIZE0) begin
            li = r_step[1:0];
            la = r_rec_q.vel_begin[16*li +: 16];
            lb = r_rec_q.vel_end[16*li +: 16];
        end else if (r_step < ppu_pkg::STEP_COLOR0) begin
            li   = 2'(r_step - ppu_pkg::STEP_SIZE0);
            la   = r_rec_q.size_begin[16*li[0] +: 16];
            lb   = r_rec_q.size_end[16*li[0] +: 16];
            lsgn = 1'b0;
        end else if (r_step < ppu_pkg::STEP_ROT) begin
            li   = 2'(r_step - ppu_pkg::STEP_COLOR0);
            la   = r_rec_q.color_begin[16*li +: 16];
            lb   = r_rec_q.color_end[16*li +: 16];
            lsgn = 1'b0;
        end else if (r_step == ppu_pkg::STEP_ROT) begin
            la = r_rec_q.rotation_pair[15:0];
            lb = r_rec_q.rotation_pair[31:16];
        end else begin
            li     = 2'(r_step - ppu_pkg::STEP_POS0);
            is_pos = 1'b1;
        end
        a17 = lsgn ? $signed({la[15], la}) : $signed({1'b0, la});
        b17 = lsgn ? $signed({lb[15], lb}) : $signed({1'b0, lb});
        d17 = b17 - a17;

        vel_sel = r_vel[(li == 2'd3) ? 2'd0 : li];
        if (is_pos) begin
            // velocity split: low 17 bits unsigned, upper bits signed
            m_a = r_ph[0] ? ppu_pkg::MA_W'($signed(vel_sel[ppu_pkg::VEL_W-1:17]))
                          : $signed({3'b000, vel_sel[16:0]});
            m_b = r_e;
        end else begin
            m_a = ppu_pkg::MA_W'(d17);
            m_b = r_ph[0] ? {1'b0, r_f[ppu_pkg::F_W-1:17]} : r_f[16:0];
        end
        prod_c = m_a * $signed({1'b0, m_b});

        acc_sh16 = r_acc >>> 16;
        acc_sh12 = r_acc >>> 12;
        lerp_v   = ppu_pkg::FIN_W'(a17) + ppu_pkg::FIN_W'(acc_sh16);
        pos_v    = ppu_pkg::FIN_W'($signed(r_rec_q.position[16*li +: 16]))
                 + ppu_pkg::FIN_W'(acc_sh12);
    end

    assign o_cmd_pop  = (r_state == S_IDLE) && !i_cmd_empty;
    assign o_res_push = r_push;
    assign o_res      = r_out;

    // slot store: registered read at the walk index, writes from emit and tick
    always_ff @(posedge i_clk) begin
        r_rec_q <= r_rec_mem[r_slot];
        r_tr_q  <= r_tr_mem[r_slot];
        if (o_cmd_pop && !i_cmd.is_tick) begin
            r_rec_mem[r_next] <= i_cmd.rec;
            r_tr_mem[r_next]  <= $signed({1'b0, i_cmd.rec.lifetime});
        end else if ((r_state == S_CHECK) && live) begin
            r_tr_mem[r_slot]  <= new18[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= '0;
            r_next   <= LAST_SLOT;
            r_slot   <= '0;
            r_pend_v <= 1'b0;
            r_push   <= 1'b0;
            r_step   <= '0;
            r_ph     <= '0;
        end else begin
            r_push <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        if (i_cmd.is_tick) begin
                            r_dt    <= i_cmd.dt;
                            r_slot  <= '0;
                            r_state <= S_READ;
                        end else begin
                            r_active[r_next] <= 1'b1;
                            r_next <= (r_next == '0) ? LAST_SLOT : r_next - 1'b1;
                        end
                    end
                end
                S_READ: begin
                    if (r_active[r_slot]) begin
                        r_state <= S_CHECK;
                    end else if (r_slot == LAST_SLOT) begin
                        r_state <= S_FLUSH;
                    end else begin
                        r_slot <= r_slot + 1'b1;
                    end
                end
                S_CHECK: begin
                    if (live) begin
                        r_e     <= e_c;
                        r_state <= S_DIV;
                    end else begin
                        r_active[r_slot] <= 1'b0;
                        if (r_slot == LAST_SLOT) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_slot  <= r_slot + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_f     <= div_quot;
                        r_step  <= '0;
                        r_ph    <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    r_ph <= r_ph + 2'd1;
                    unique case (r_ph)
                        2'd0: r_prod <= prod_c;
                        2'd1: begin
                            r_acc  <= ppu_pkg::ACC_W'(r_prod);
                            r_prod <= prod_c;
                        end
                        2'd2: r_acc <= r_acc + (ppu_pkg::ACC_W'(r_prod) <<< 17);
                        default: begin
                            priority if (r_step < ppu_pkg::STEP_SIZE0) begin
                                r_vel[li] <= lerp_v[ppu_pkg::VEL_W-1:0];
                            end else if (r_step < ppu_pkg::STEP_COLOR0) begin
                                r_cur.size[16*li[0] +: 16] <= ppu_pkg::sat_u16(lerp_v);
                            end else if (r_step < ppu_pkg::STEP_ROT) begin
                                r_cur.color[16*li +: 16] <= ppu_pkg::sat_u16(lerp_v);
                            end else if (r_step == ppu_pkg::STEP_ROT) begin
                                r_cur.rotation <= ppu_pkg::sat_s16(lerp_v);
                            end else begin
                                r_cur.position[16*li +: 16] <= ppu_pkg::sat_s16(pos_v);
                            end
                            if (r_step == ppu_pkg::STEP_LAST) begin
                                r_state <= S_PUSH;
                            end else begin
                                r_step <= r_step + 4'd1;
                            end
                        end
                    endcase
                end
                S_PUSH: begin
                    // previous result goes out once a later one is known
                    if (!(r_pend_v && (i_res_full || r_push))) begin
                        if (r_pend_v) begin
                            r_out.res  <= r_pend;
                            r_out.last <= 1'b0;
                            r_push     <= 1'b1;
                        end
                        r_pend   <= r_cur;
                        r_pend_v <= 1'b1;
                        if (r_slot == LAST_SLOT) begin
                            r_state <= S_FLUSH;
                        end else begin
                            r_slot  <= r_slot + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_FLUSH: begin
                    if (!r_pend_v) begin
                        r_state <= S_IDLE;
                    end else if (!i_res_full && !r_push) begin
                        r_out.res  <= r_pend;
                        r_out.last <= 1'b1;
                        r_push     <= 1'b1;
                        r_pend_v   <= 1'b0;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/particle_pool_update.sv
// ----------------------------------------------------------------------------
// particle_pool_update
// ring pool of particles: emit writes a slot, tick ages, interpolates live ones of all
// ----------------------------------------------------------------------------
// emit: written into the next ring slot by the back end, no result
// tick: empty slots are skipped; each live slot waits on the 33-step divider for
//   the life fraction, then on the shared multiplier for the interpolation
// results: each leaves once the next live slot finishes or the walk ends
// reset (i_rst_n low, synchronous) clears all slots to inactive, ring index to top slot
// ----------------------------------------------------------------------------
`default_nettype none

module particle_pool_update #(
    parameter int POOL_SIZE = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input queue side
    input  wire logic        push,
    output logic             full,
    input  wire logic        i_opcode,
    input  wire logic [15:0] i_delta_time,
    input  wire logic [47:0] i_start_position,
    input  wire logic [47:0] i_begin_velocity,
    input  wire logic [47:0] i_end_velocity,
    input  wire logic [63:0] i_begin_color,
    input  wire logic [63:0] i_end_color,
    input  wire logic [31:0] i_begin_size,
    input  wire logic [31:0] i_end_size,
    input  wire logic signed [15:0] i_begin_rotation,
    input  wire logic signed [15:0] i_end_rotation,
    input  wire logic [15:0] i_life_time,
    // result queue side
    output logic             empty,
    input  wire logic        pop,
    output logic [47:0]      o_out_position,
    output logic [31:0]      o_out_size,
    output logic [63:0]      o_out_color,
    output logic signed [15:0] o_out_rotation,
    output logic             o_last_of_tick
);

    // front to back command transfer
    logic          cmd_empty;
    logic          cmd_pop;
    ppu_pkg::t_cmd cmd;

    // back to result queue transfer
    logic          res_push;
    logic          res_full;
    ppu_pkg::t_out res_in;
    logic [$bits(ppu_pkg::t_out)-1:0] res_q;
    ppu_pkg::t_out res_out;

    // front: classify and queue incoming items
    ppu_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_opcode         (i_opcode),
        .i_delta_time     (i_delta_time),
        .i_start_position (i_start_position),
        .i_begin_velocity (i_begin_velocity),
        .i_end_velocity   (i_end_velocity),
        .i_begin_color    (i_begin_color),
        .i_end_color      (i_end_color),
        .i_begin_size     (i_begin_size),
        .i_end_size       (i_end_size),
        .i_begin_rotation (i_begin_rotation),
        .i_end_rotation   (i_end_rotation),
        .i_life_time      (i_life_time),
        .o_cmd_empty      (cmd_empty),
        .i_cmd_pop        (cmd_pop),
        .o_cmd            (cmd)
    );

    // back: slot store, walk sequencer, divider and multiply datapath
    ppu_back #(
        .POOL_SIZE (POOL_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .o_res_push  (res_push),
        .i_res_full  (res_full),
        .o_res       (res_in)
    );

    // result queue decouples the walk from the consumer
    ppu_fifo #(
        .WIDTH ($bits(ppu_pkg::t_out))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .o_full  (res_full),
        .i_data  (res_in),
        .o_empty (empty),
        .i_pop   (pop),
        .o_data  (res_q)
    );

    assign res_out        = ppu_pkg::t_out'(res_q);
    assign o_out_position = res_out.res.position;
    assign o_out_size     = res_out.res.size;
    assign o_out_color    = res_out.res.color;
    assign o_out_rotation = $signed(res_out.res.rotation);
    assign o_last_of_tick = res_out.last;

endmodule

`default_nettype wire
